@@ hw/rtl/two_level_page_walk_32_defines.svh @@
// Assertion macros for the page walk block.
`ifndef TWO_LEVEL_PAGE_WALK_32_DEFINES_SVH
`define TWO_LEVEL_PAGE_WALK_32_DEFINES_SVH

`ifndef SYNTH
`define LPW_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("page walk assertion failed");
`define LPW_ASSERT_NORST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("page walk assertion failed");
`else
`define LPW_ASSERT(lbl, clk, rst_n, prop)
`define LPW_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

@@ hw/rtl/lpw_pkg.sv @@
package lpw_pkg;

	localparam int unsigned STORE_WORDS_DEF = 4096;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_XLATE = 1'b1;

	localparam logic [2:0] WS_SMALL  = 3'd0;
	localparam logic [2:0] WS_LARGE  = 3'd1;
	localparam logic [2:0] WS_DIR_NP = 3'd2;
	localparam logic [2:0] WS_TBL_NP = 3'd3;
	localparam logic [2:0] WS_NO_DIR = 3'd4;

	localparam logic [1:0] ACC_OK     = 2'd0;
	localparam logic [1:0] ACC_NP     = 2'd1;
	localparam logic [1:0] ACC_WR_DEN = 2'd2;
	localparam logic [1:0] ACC_US_DEN = 2'd3;
	localparam logic [2:0] TACC_NA    = 3'd4;

	localparam int unsigned BIT_P  = 0;
	localparam int unsigned BIT_RW = 1;
	localparam int unsigned BIT_US = 2;
	localparam int unsigned BIT_PS = 7;

	typedef struct packed {
		logic re;
		logic we;
	} mem_cmd_t;

	function automatic logic [1:0] check_entry(input logic [31:0] e, input logic wr,
		input logic usr);
		logic [1:0] r;
		if (!e[BIT_P]) begin
			r = ACC_NP;
		end else if (!e[BIT_RW] && wr) begin
			r = ACC_WR_DEN;
		end else if (!e[BIT_US] && usr) begin
			r = ACC_US_DEN;
		end else begin
			r = ACC_OK;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/lpw_store.sv @@
module lpw_store #(
	parameter int unsigned STORE_WORDS = lpw_pkg::STORE_WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lpw_pkg::mem_cmd_t              cmd,
	input  logic [$clog2(STORE_WORDS)-1:0] addr,
	input  logic [31:0]                    wdata,
	output logic [31:0]                    rdata,
	output logic                           clearing
);
	import lpw_pkg::*;

	localparam int unsigned AW = $clog2(STORE_WORDS);

	logic [31:0]   mem [STORE_WORDS];
	logic [AW-1:0] clr_cnt_q;
	logic          clr_busy_q;
	logic [31:0]   rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(STORE_WORDS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (cmd.we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata    = rdata_q;
	assign clearing = clr_busy_q;

endmodule

@@ hw/rtl/lpw_ctrl.sv @@
`include "two_level_page_walk_32_defines.svh"

module lpw_ctrl #(
	parameter int unsigned STORE_WORDS = lpw_pkg::STORE_WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [31:0]                    dir_base,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           command,
	input  logic [11:0]                    word_index,
	input  logic [31:0]                    word_data,
	input  logic [31:0]                    virt_addr,
	input  logic                           is_write,
	input  logic                           is_user,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [31:0]                    phys_addr,
	output logic [2:0]                     walk_status,
	output logic [1:0]                     dir_access,
	output logic [2:0]                     table_access,
	output lpw_pkg::mem_cmd_t              mem_cmd,
	output logic [$clog2(STORE_WORDS)-1:0] mem_addr,
	output logic [31:0]                    mem_wdata,
	input  logic [31:0]                    mem_rdata,
	input  logic                           mem_clearing
);
	import lpw_pkg::*;

	localparam int unsigned AW = $clog2(STORE_WORDS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIR  = 2'd1;
	localparam logic [1:0] ST_TBL  = 2'd2;

	logic [1:0]  state_q;
	logic        cmd_q;
	logic [31:0] va_q;
	logic        wr_q;
	logic        usr_q;
	logic        nobase_q;
	logic        oor_q;
	logic [1:0]  dacc_q;

	logic        out_valid_q;
	logic [31:0] phys_q;
	logic [2:0]  ws_q;
	logic [1:0]  da_q;
	logic [2:0]  ta_q;

	logic        acc;
	logic        nobase;
	logic [29:0] pde_wa;
	logic        pde_oor;
	logic        wi_ok;
	logic [31:0] ent;
	logic [29:0] pte_wa;
	logic        pte_oor;
	logic [1:0]  ent_acc;
	logic        go_tbl;
	logic        fin;
	logic        load;
	logic [31:0] r_phys;
	logic [2:0]  r_ws;
	logic [1:0]  r_da;
	logic [2:0]  r_ta;

	assign in_ready = (state_q == ST_IDLE) && !mem_clearing;
	assign acc      = in_valid && in_ready;
	assign nobase   = (dir_base[31:12] == 20'd0);
	assign pde_wa   = {dir_base[31:12], virt_addr[31:22]};
	assign pde_oor  = ({2'b00, pde_wa} >= 32'(STORE_WORDS));
	assign wi_ok    = (32'(word_index) < 32'(STORE_WORDS));

	assign ent     = oor_q ? 32'd0 : mem_rdata;
	assign ent_acc = check_entry(ent, wr_q, usr_q);
	assign pte_wa  = {ent[31:12], va_q[21:12]};
	assign pte_oor = ({2'b00, pte_wa} >= 32'(STORE_WORDS));
	assign go_tbl  = (state_q == ST_DIR) && (cmd_q == CMD_XLATE) && !nobase_q
		&& ent[BIT_P] && !ent[BIT_PS];

	always_comb begin
		mem_cmd.we = acc && (command == CMD_WRITE) && wi_ok;
		mem_cmd.re = (acc && (command == CMD_XLATE) && !nobase && !pde_oor)
			|| (go_tbl && !pte_oor);
		mem_wdata  = word_data;
		if (state_q == ST_IDLE) begin
			mem_addr = (command == CMD_WRITE) ? AW'(word_index) : pde_wa[AW-1:0];
		end else begin
			mem_addr = pte_wa[AW-1:0];
		end
	end

	always_comb begin
		r_phys = 32'd0;
		r_ws   = WS_SMALL;
		r_da   = ACC_OK;
		r_ta   = {1'b0, ACC_OK};
		if (state_q == ST_TBL) begin
			r_da = dacc_q;
			r_ta = {1'b0, ent_acc};
			if (!ent[BIT_P]) begin
				r_ws = WS_TBL_NP;
			end else begin
				r_phys = {ent[31:12], va_q[11:0]};
				r_ws   = WS_SMALL;
			end
		end else if (cmd_q == CMD_XLATE) begin
			r_ta = TACC_NA;
			if (nobase_q) begin
				r_ws = WS_NO_DIR;
				r_da = ACC_NP;
			end else begin
				r_da = ent_acc;
				if (!ent[BIT_P]) begin
					r_ws = WS_DIR_NP;
				end else begin
					r_phys = {ent[31:22], va_q[21:0]};
					r_ws   = WS_LARGE;
				end
			end
		end
	end

	assign fin  = ((state_q == ST_DIR) && !go_tbl) || (state_q == ST_TBL);
	assign load = fin && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q <= ST_DIR;
					end
				end
				ST_DIR: begin
					if (go_tbl) begin
						state_q <= ST_TBL;
					end else if (load) begin
						state_q <= ST_IDLE;
					end
				end
				ST_TBL: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q    <= command;
			va_q     <= virt_addr;
			wr_q     <= is_write;
			usr_q    <= is_user;
			nobase_q <= nobase;
			oor_q    <= pde_oor;
		end else if (go_tbl) begin
			oor_q  <= pte_oor;
			dacc_q <= ent_acc;
		end
		if (load) begin
			phys_q <= r_phys;
			ws_q   <= r_ws;
			da_q   <= r_da;
			ta_q   <= r_ta;
		end
	end

	assign out_valid    = out_valid_q;
	assign phys_addr    = phys_q;
	assign walk_status  = ws_q;
	assign dir_access   = da_q;
	assign table_access = ta_q;

	`LPW_ASSERT(a_tbl_after_dir, clk, arst_n,
		(state_q == ST_TBL) |-> ($past(state_q) == ST_DIR || $past(state_q) == ST_TBL))
	`LPW_ASSERT(a_accept_starts, clk, arst_n, acc |=> (state_q == ST_DIR))
	`LPW_ASSERT(a_no_accept_clear, clk, arst_n, mem_clearing |-> !in_ready)
	`LPW_ASSERT(a_ta_na, clk, arst_n,
		(out_valid_q && (ws_q == WS_LARGE || ws_q == WS_DIR_NP || ws_q == WS_NO_DIR))
		|-> (ta_q == TACC_NA))
	`LPW_ASSERT(a_ok_dir_present, clk, arst_n,
		(out_valid_q && (ws_q == WS_SMALL || ws_q == WS_LARGE)
		&& (ta_q != {1'b0, ACC_OK} || ws_q == WS_LARGE) && phys_q != 32'd0)
		|-> (da_q != ACC_NP))

endmodule

@@ hw/rtl/two_level_page_walk_32.sv @@
// Two-level 32-bit page walk over an internal table store of STORE_WORDS words.
// Input channel (in_valid/in_ready): command 0 writes word_data at word_index
// (an index beyond the store is dropped); command 1 translates virt_addr
// against the directory at dir_base, checking is_write/is_user at each level.
// Output channel (out_valid/out_ready): one beat per input beat, in order.
// Configuration: cfg_we writes cfg_wdata into the dir_base register.
// A write, a missing directory, an absent directory entry or a large page
// finishes in the DIR state; a walk that reads a table entry goes on from DIR
// to TBL. Each table level is one read of the single-port store, and the
// next item is taken only after the current one has finished.
// A finished result sits in the output register while the next item is taken;
// when the receiver stalls, the walk in flight holds its last read and waits.
// Reset clears dir_base and starts a clearing pass that zeroes the store, one
// word a cycle, through all STORE_WORDS words; in_ready stays low until it ends.
module two_level_page_walk_32 #(
	parameter int unsigned STORE_WORDS = lpw_pkg::STORE_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [11:0] word_index,
	input  logic [31:0] word_data,
	input  logic [31:0] virt_addr,
	input  logic        is_write,
	input  logic        is_user,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] phys_addr,
	output logic [2:0]  walk_status,
	output logic [1:0]  dir_access,
	output logic [2:0]  table_access
);
	import lpw_pkg::*;

	localparam int unsigned AW = $clog2(STORE_WORDS);

	logic [31:0]   dir_base_q;
	mem_cmd_t      mem_cmd;
	logic [AW-1:0] mem_addr;
	logic [31:0]   mem_wdata;
	logic [31:0]   mem_rdata;
	logic          mem_clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_base_q <= 32'd0;
		end else if (cfg_we) begin
			dir_base_q <= cfg_wdata;
		end
	end

	lpw_store #(
		.STORE_WORDS(STORE_WORDS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (mem_cmd),
		.addr     (mem_addr),
		.wdata    (mem_wdata),
		.rdata    (mem_rdata),
		.clearing (mem_clearing)
	);

	lpw_ctrl #(
		.STORE_WORDS(STORE_WORDS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.dir_base     (dir_base_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.word_index   (word_index),
		.word_data    (word_data),
		.virt_addr    (virt_addr),
		.is_write     (is_write),
		.is_user      (is_user),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.phys_addr    (phys_addr),
		.walk_status  (walk_status),
		.dir_access   (dir_access),
		.table_access (table_access),
		.mem_cmd      (mem_cmd),
		.mem_addr     (mem_addr),
		.mem_wdata    (mem_wdata),
		.mem_rdata    (mem_rdata),
		.mem_clearing (mem_clearing)
	);

endmodule

@@ sim/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lpw_pkg::*;

	localparam int unsigned STORE_WORDS = STORE_WORDS_DEF;
	localparam int unsigned PRESSURE_CYCLES = 300;

	typedef struct packed {
		logic        command;
		logic [11:0] word_index;
		logic [31:0] word_data;
		logic [31:0] virt_addr;
		logic        is_write;
		logic        is_user;
	} walk_request_t;

	typedef struct packed {
		logic [31:0] phys_addr;
		logic [2:0]  walk_status;
		logic [1:0]  dir_access;
		logic [2:0]  table_access;
	} walk_result_t;

	class walk_scoreboard;
		logic [31:0]  store_words [STORE_WORDS];
		logic [31:0]  dir_base;
		walk_result_t pending_walks [$];
		int unsigned  errors;

		function new();
			foreach (store_words[i]) begin
				store_words[i] = '0;
			end
			dir_base = '0;
			errors = 0;
		endfunction

		function void set_dir_base(input logic [31:0] value);
			dir_base = value;
		endfunction

		function logic [31:0] fetch(input logic [31:0] byte_addr);
			if (byte_addr[31:2] >= STORE_WORDS) begin
				return '0;
			end
			return store_words[byte_addr[31:2]];
		endfunction

		function logic [1:0] grade_entry(input logic [31:0] e, input logic wr, input logic usr);
			if (!e[BIT_P]) begin
				return ACC_NP;
			end
			if (!e[BIT_RW] && wr) begin
				return ACC_WR_DEN;
			end
			if (!e[BIT_US] && usr) begin
				return ACC_US_DEN;
			end
			return ACC_OK;
		endfunction

		function walk_result_t translate(input walk_request_t req);
			walk_result_t res;
			logic [31:0]  base;
			logic [31:0]  pde;
			logic [31:0]  pte;
			res = '0;
			if (req.command == CMD_WRITE) begin
				if (req.word_index < STORE_WORDS) begin
					store_words[req.word_index] = req.word_data;
				end
				return res;
			end
			base = {dir_base[31:12], 12'h000};
			if (base == '0) begin
				res.walk_status = WS_NO_DIR;
				res.dir_access = ACC_NP;
				res.table_access = TACC_NA;
				return res;
			end
			pde = fetch(base + {20'd0, req.virt_addr[31:22], 2'b00});
			res.dir_access = grade_entry(pde, req.is_write, req.is_user);
			if (!pde[BIT_P]) begin
				res.walk_status = WS_DIR_NP;
				res.table_access = TACC_NA;
			end else if (pde[BIT_PS]) begin
				res.phys_addr = {pde[31:22], req.virt_addr[21:0]};
				res.walk_status = WS_LARGE;
				res.table_access = TACC_NA;
			end else begin
				pte = fetch({pde[31:12], 12'h000} + {20'd0, req.virt_addr[21:12], 2'b00});
				res.table_access = {1'b0, grade_entry(pte, req.is_write, req.is_user)};
				if (!pte[BIT_P]) begin
					res.walk_status = WS_TBL_NP;
				end else begin
					res.phys_addr = {pte[31:12], req.virt_addr[11:0]};
					res.walk_status = WS_SMALL;
				end
			end
			return res;
		endfunction

		function void note_request(input walk_request_t req);
			pending_walks.push_back(translate(req));
		endfunction

		function void check_walk(input walk_result_t got);
			walk_result_t want;
			if (pending_walks.size() == 0) begin
				$error("unexpected result beat: phys_addr %h walk_status %0d", got.phys_addr,
					got.walk_status);
				errors++;
				return;
			end
			want = pending_walks.pop_front();
			if (got.phys_addr !== want.phys_addr) begin
				$error("phys_addr: expected %h, got %h", want.phys_addr, got.phys_addr);
				errors++;
			end
			if (got.walk_status !== want.walk_status) begin
				$error("walk_status: expected %0d, got %0d", want.walk_status, got.walk_status);
				errors++;
			end
			if (got.dir_access !== want.dir_access) begin
				$error("dir_access: expected %0d, got %0d", want.dir_access, got.dir_access);
				errors++;
			end
			if (got.table_access !== want.table_access) begin
				$error("table_access: expected %0d, got %0d", want.table_access,
					got.table_access);
				errors++;
			end
		endfunction

		function int unsigned outstanding();
			return pending_walks.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        command = CMD_WRITE;
	logic [11:0] word_index = '0;
	logic [31:0] word_data = '0;
	logic [31:0] virt_addr = '0;
	logic        is_write = 1'b0;
	logic        is_user = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] phys_addr;
	logic [2:0]  walk_status;
	logic [1:0]  dir_access;
	logic [2:0]  table_access;

	walk_scoreboard walks;
	int unsigned    send_idle_pct = 0;
	int unsigned    stall_pct = 0;
	logic           hold_armed = 1'b0;
	int unsigned    held_cycles = 0;
	logic [9:0]     hot_dir [8];
	logic [9:0]     hot_tbl [8];

	two_level_page_walk_32 #(
		.STORE_WORDS(STORE_WORDS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.word_index(word_index),
		.word_data(word_data),
		.virt_addr(virt_addr),
		.is_write(is_write),
		.is_user(is_user),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.phys_addr(phys_addr),
		.walk_status(walk_status),
		.dir_access(dir_access),
		.table_access(table_access)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		if (hold_armed && held_cycles < PRESSURE_CYCLES) begin
			out_ready <= 1'b0;
			held_cycles <= held_cycles + 1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			walks.check_walk(walk_result_t'{phys_addr, walk_status, dir_access, table_access});
		end
	end

	function automatic walk_request_t xlate(input logic [31:0] va, input logic wr,
		input logic usr);
		walk_request_t r;
		r = '0;
		r.command = CMD_XLATE;
		r.virt_addr = va;
		r.is_write = wr;
		r.is_user = usr;
		return r;
	endfunction

	function automatic walk_request_t store_word(input logic [11:0] idx, input logic [31:0] data);
		walk_request_t r;
		r = '0;
		r.command = CMD_WRITE;
		r.word_index = idx;
		r.word_data = data;
		return r;
	endfunction

	// enter and leave at a falling edge; valid stays high for the next beat
	task automatic offer_beat(input walk_request_t req);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= req.command;
		word_index <= req.word_index;
		word_data <= req.word_data;
		virt_addr <= req.virt_addr;
		is_write <= req.is_write;
		is_user <= req.is_user;
		do begin
			@(posedge clk);
		end while (!in_ready);
		walks.note_request(req);
		@(negedge clk);
	endtask

	// drop valid, wait out every result, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (walks.outstanding() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_dir_base(input logic [31:0] value);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		walks.set_dir_base(value);
		@(negedge clk);
	endtask

	task automatic run_walks(input int unsigned count);
		walk_request_t req;
		int unsigned   pick;
		for (int unsigned n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			req.command = 1'($urandom);
			req.word_index = 12'($urandom);
			req.word_data = $urandom;
			req.virt_addr = $urandom;
			req.is_write = 1'($urandom);
			req.is_user = 1'($urandom);
			if (pick < 20) begin
				req.command = CMD_WRITE;
				req.word_index = {walks.dir_base[13:12], hot_dir[$urandom_range(0, 7)]};
				req.word_data[BIT_PS] = ($urandom_range(0, 3) == 0);
				if (!req.word_data[BIT_PS] && $urandom_range(0, 9) != 0) begin
					req.word_data[31:12] = 20'($urandom_range(0, 3));
				end
				req.word_data[BIT_P] = ($urandom_range(0, 9) != 0);
			end else if (pick < 45) begin
				req.command = CMD_WRITE;
				req.word_index = {2'($urandom_range(0, 3)), hot_tbl[$urandom_range(0, 7)]};
				req.word_data[BIT_P] = ($urandom_range(0, 9) != 0);
			end else if (pick < 90) begin
				req.command = CMD_XLATE;
				req.virt_addr[31:22] = hot_dir[$urandom_range(0, 7)];
				req.virt_addr[21:12] = hot_tbl[$urandom_range(0, 7)];
			end
			offer_beat(req);
		end
	endtask

	initial begin
		#(5_000_000);
		$display("testbench failed");
		$finish;
	end

	initial begin
		int unsigned send_pace [4];
		int unsigned recv_pace [4];
		send_pace = '{0, 86, 0, 29};
		recv_pace = '{0, 0, 86, 29};
		walks = new();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		offer_beat(xlate(32'hFFFF_FFFF, 1'b1, 1'b1));
		offer_beat(store_word(12'hFFF, 32'hFFFF_FFFF));
		settle();
		write_dir_base(32'h0000_0FFF);
		offer_beat(xlate(32'h0000_0000, 1'b0, 1'b0));
		settle();
		write_dir_base(32'h0000_1000);
		offer_beat(xlate(32'h0000_0000, 1'b0, 1'b0));
		offer_beat(store_word(12'd1024, 32'h0000_2007));
		offer_beat(store_word(12'd2048, 32'hABCD_E003));
		offer_beat(xlate(32'h0000_0123, 1'b0, 1'b0));
		offer_beat(xlate(32'h0000_0FFF, 1'b1, 1'b1));
		offer_beat(xlate(32'h0000_1000, 1'b0, 1'b0));
		offer_beat(store_word(12'd2047, 32'hFFC0_0081));
		offer_beat(xlate(32'hFFFF_FFFF, 1'b1, 1'b0));
		offer_beat(xlate(32'hFFC0_0000, 1'b0, 1'b1));
		offer_beat(store_word(12'd1025, 32'h0000_3005));
		offer_beat(store_word(12'd3077, 32'h1234_5001));
		offer_beat(xlate(32'h0040_5ABC, 1'b1, 1'b1));
		offer_beat(store_word(12'd1026, 32'hFFFF_F001));
		offer_beat(xlate(32'h0080_0000, 1'b0, 1'b0));
		offer_beat(store_word(12'd0, 32'h0000_0000));
		offer_beat(store_word(12'd1027, 32'hFFFF_FFFE));
		offer_beat(xlate(32'h00C0_0000, 1'b1, 1'b1));
		settle();
		write_dir_base(32'hFFFF_F000);
		offer_beat(xlate(32'h0000_0000, 1'b1, 1'b0));

		for (int p = 0; p < 4; p++) begin
			for (int s = 0; s < 2; s++) begin
				settle();
				if (s == 0) begin
					@(posedge clk);
					send_idle_pct = send_pace[p];
					stall_pct = recv_pace[p];
					if (p == 0) begin
						hold_armed = 1'b1;
					end
					@(negedge clk);
				end
				write_dir_base({18'd0, 2'($urandom_range(1, 3)), 12'($urandom)});
				foreach (hot_dir[i]) begin
					hot_dir[i] = 10'($urandom);
					hot_tbl[i] = 10'($urandom);
				end
				hot_dir[0] = '0;
				hot_dir[7] = '1;
				hot_tbl[0] = '0;
				hot_tbl[7] = '1;
				run_walks(250);
			end
		end

		settle();
		if (walks.errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule
